[src/ilid_pkg.sv]
// Package for the indexed list block: sizes, command and status codes,
// and the control word broadcast to every list cell. No dependencies.
package ilid_pkg;

    localparam int CAPACITY     = 64;
    localparam int LEN_W        = $clog2(CAPACITY + 1);
    localparam int INDEX_W      = 8;
    localparam int CMP_W        = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int LENGTH_OUT_W = 7;

    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BEFORE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Control word seen by every cell in the same cycle.
    typedef struct packed {
        logic              ins;     // insert value at pos, shift the tail up
        logic              del;     // remove element at pos, shift the tail down
        logic [CMP_W-1:0]  pos;     // insert or delete position
        logic [CMP_W-1:0]  len;     // list length before the command
        logic [CMP_W-1:0]  rd_idx;  // index to drive onto the read bus
        logic [DATA_W-1:0] value;   // value to insert
    } t_ctrl;

endpackage

[src/ilid_cell.sv]
// One list cell: holds one element and takes a neighbor's word on a shift.
// Depends on ilid_pkg for sizes and the control word.
module ilid_cell
    import ilid_pkg::*;
(
    input  logic              i_clk,
    input  t_ctrl             i_ctrl,
    input  logic [CMP_W-1:0]  i_pos,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_hit_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (i_pos == i_ctrl.pos) begin
                n_data = i_ctrl.value;
            end else if ((i_pos > i_ctrl.pos) && (i_pos <= i_ctrl.len)) begin
                n_data = i_left;
            end
        end else if (i_ctrl.del) begin
            if ((i_pos >= i_ctrl.pos) && ((i_pos + CMP_W'(1)) < i_ctrl.len)) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    // Only the addressed cell puts its word on the shared OR read bus.
    assign o_hit_data = (i_pos == i_ctrl.rd_idx) ? r_data : '0;

endmodule

[src/indexed_list_insert_delete.sv]
// Top level of the indexed list: command decode, length register, row of cells
// and the registered result word. Depends on ilid_pkg and ilid_cell.
//
// Usage:
// A command word (i_command, i_index, i_value) is taken at every rising clock
// edge at which start is high and busy is low. busy stays low: each command is
// finished in the cycle it is taken, so a new command can follow every cycle.
// The list is a row of CAPACITY cells, one element per cell. On an insert the
// cell at the position loads the new value and the later cells up to the length
// load their left neighbor's word; on a delete the cells from the position to
// the one before the last element load their right neighbor's word, all in the
// same clock edge. A read is served by the addressed cell driving an OR bus. The
// result word (o_read_value, o_status, o_length) appears in the cycle after the
// command is taken and is valid for exactly one cycle while o_strobe is high.
// The receiver cannot stall; results are not held. One command per cycle.
// Reset (i_rst_n low at a clock edge) empties the list and drops any pending
// result; element contents are not cleared since cells beyond the length are
// never read. An insert into a full list returns the full status, and an index
// out of range returns the invalid status; neither changes the list.
module indexed_list_insert_delete
    import ilid_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [INDEX_W-1:0]        i_index,
    input  logic signed [DATA_W-1:0]  i_value,
    output logic                      o_strobe,
    output logic signed [DATA_W-1:0]  o_read_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic [LENGTH_OUT_W-1:0]   o_length
);

    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    n_len;
    logic                r_strobe;
    logic [DATA_W-1:0]   r_read_value;
    logic [DATA_W-1:0]   n_read_value;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    t_ctrl               ctrl;
    logic [CMP_W-1:0]    len_c;
    logic [CMP_W-1:0]    idx_c;
    logic                full;
    logic [DATA_W-1:0]   read_bus;
    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [DATA_W-1:0]   hit_data  [CAPACITY];

    // Every command completes in the cycle it is taken, so the block never holds off.
    assign busy = 1'b0;

    assign len_c = CMP_W'(r_len);
    assign idx_c = CMP_W'(i_index);
    assign full  = (r_len == LEN_W'(CAPACITY));

    // Decode: choose the operation for the cells and the result fields.
    always_comb begin
        ctrl.ins     = 1'b0;
        ctrl.del     = 1'b0;
        ctrl.pos     = idx_c;
        ctrl.len     = len_c;
        ctrl.rd_idx  = idx_c;
        ctrl.value   = i_value;
        n_len        = r_len;
        n_read_value = '0;
        n_status     = ST_DONE;
        unique case (i_command)
            CMD_READ: begin
                if (idx_c < len_c) begin
                    n_read_value = read_bus;
                end else begin
                    n_read_value = '1;
                    n_status     = ST_INVALID;
                end
            end
            CMD_FRONT: begin
                ctrl.pos = '0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                end
            end
            CMD_BACK: begin
                ctrl.pos = len_c;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                end
            end
            CMD_BEFORE: begin
                if (idx_c > len_c) begin
                    n_status = ST_INVALID;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (idx_c < len_c) begin
                    ctrl.del = 1'b1;
                end else begin
                    n_status = ST_INVALID;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
        // The list and length change only when a command is actually taken this cycle.
        if (!start) begin
            ctrl.ins = 1'b0;
            ctrl.del = 1'b0;
        end
        if (ctrl.ins) begin
            n_len = r_len + LEN_W'(1);
        end else if (ctrl.del) begin
            n_len = r_len - LEN_W'(1);
        end
    end

    // The row of cells; the ends see zero from outside the row.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_inner_l
            assign left_w = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner_r
            assign right_w = cell_data[g+1];
        end
        ilid_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_pos      (CMP_W'(g)),
            .i_left     (left_w),
            .i_right    (right_w),
            .o_data     (cell_data[g]),
            .o_hit_data (hit_data[g])
        );
    end

    // At most one cell matches the read index, so an OR of all cells
    // yields the addressed element.
    always_comb begin
        read_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            read_bus = read_bus | hit_data[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_strobe <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_value <= n_read_value;
        r_status     <= n_status;
    end

    assign o_strobe     = r_strobe;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_length     = LENGTH_OUT_W'(r_len);

    // The length never exceeds the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    // A full status is only reported while the list is full.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL)) |-> full)
        else $error("full status with free room");

    // A command that was refused leaves the length unchanged.
    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_DONE)) |-> (r_len == $past(r_len)))
        else $error("length changed on a refused command");

    // Every taken command yields exactly one result word in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("missing result word");

endmodule
